FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the attribute video memory pixel unit.
// Each macro checks a property on the rising edge of clk_i, disabled in reset.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(name, prop)
`define ASSERT_NEVER(name, expr)
`endif
`endif

FILE: src/avmpu_pkg.sv
// Shared types and constants of the attribute video memory pixel unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package avmpu_pkg;

  // Operation codes of a transaction.
  localparam logic [2:0] MODE_RD_LATCH = 3'd0;
  localparam logic [2:0] MODE_WR_LATCH = 3'd1;
  localparam logic [2:0] MODE_CPU_RD   = 3'd2;
  localparam logic [2:0] MODE_CPU_WR   = 3'd3;
  localparam logic [2:0] MODE_FETCH    = 3'd4;

  // CPU addresses at or above this one also move attribute bits.
  localparam logic [15:0] ATTR_SPLIT = 16'h2000;

  // Bit positions inside the merged attribute byte.
  localparam int unsigned ATTR_BIT_INTENSITY = 0;
  localparam int unsigned ATTR_BIT_HIDE      = 1;
  localparam int unsigned ATTR_BIT_LATCH_WE  = 2;
  localparam int unsigned ATTR_BIT_REVERSE   = 4;
  localparam int unsigned ATTR_BIT_BLANK     = 5;
  localparam int unsigned ATTR_BIT_BOLD      = 6;
  localparam int unsigned ATTR_BIT_BLINK_PH  = 7;

  // Pixel color codes.
  localparam logic [1:0] COLOR_BLACK  = 2'd0;
  localparam logic [1:0] COLOR_NORMAL = 2'd1;
  localparam logic [1:0] COLOR_BRIGHT = 2'd2;

  // Write request from the access stage to the memories.
  typedef struct packed {
    logic       we;
    logic       attr_we;
    logic [7:0] wdata;
    logic [1:0] attr_wdata;
  } mem_req_t;

endpackage

FILE: src/avmpu_store.sv
// Video byte memory and attribute plane with a clearing sweep after reset.
// Depends on avmpu_pkg for the write request struct.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module avmpu_store #(
  parameter int unsigned MEM_ADDR_BITS = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [MEM_ADDR_BITS-1:0] addr_i,
  input  avmpu_pkg::mem_req_t      req_i,
  output logic [7:0]               vdata_o,
  output logic [1:0]               adata_o,
  output logic                     clearing_o
);

  localparam int unsigned Depth = 1 << MEM_ADDR_BITS;

  logic [7:0]               vmem [Depth];
  logic [1:0]               amem [Depth];
  logic [7:0]               vdata_q;
  logic [1:0]               adata_q;
  logic                     clear_q, clear_d;
  logic [MEM_ADDR_BITS-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clear_d   = clear_q;
    clr_cnt_d = clr_cnt_q;
    if (clear_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) begin
        clear_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clear_q   <= clear_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_q) begin
      vmem[clr_cnt_q] <= '0;
      amem[clr_cnt_q] <= '0;
    end else begin
      if (req_i.we) begin
        vmem[addr_i] <= req_i.wdata;
      end
      if (req_i.attr_we) begin
        amem[addr_i] <= req_i.attr_wdata;
      end
    end
    vdata_q <= vmem[addr_i];
    adata_q <= amem[addr_i];
  end

  assign vdata_o    = vdata_q;
  assign adata_o    = adata_q;
  assign clearing_o = clear_q;

  `ASSERT_NEVER(a_attr_we_alone, req_i.attr_we && !req_i.we)
  `ASSERT_AT(a_clear_ends_once, $fell(clear_q) |-> $past(clr_cnt_q) == '1)
  `ASSERT_NEVER(a_clear_restarts, $rose(clear_q))

endmodule

FILE: src/avmpu_pixel.sv
// Expands one video byte into eight 2-bit color codes under an attribute byte.
// Depends on avmpu_pkg for attribute bit positions and color codes.
`timescale 1ns / 1ps
module avmpu_pixel (
  input  logic [7:0]  data_i,
  input  logic [7:0]  attr_i,
  output logic [15:0] pixels_o
);

  logic       hide;
  logic       bright_sel;
  logic [1:0] color [8];

  assign hide = attr_i[avmpu_pkg::ATTR_BIT_HIDE] & ~attr_i[avmpu_pkg::ATTR_BIT_BLINK_PH];
  assign bright_sel = ~attr_i[avmpu_pkg::ATTR_BIT_BOLD] ^ attr_i[avmpu_pkg::ATTR_BIT_INTENSITY];

  // Each pixel is independent; the leftmost pixel is data bit 7.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      logic bit_on;
      bit_on = (data_i[7-i] & ~hide) ^ attr_i[avmpu_pkg::ATTR_BIT_REVERSE];
      if (attr_i[avmpu_pkg::ATTR_BIT_BLANK] || !bit_on) begin
        color[i] = avmpu_pkg::COLOR_BLACK;
      end else if (bright_sel) begin
        color[i] = avmpu_pkg::COLOR_BRIGHT;
      end else begin
        color[i] = avmpu_pkg::COLOR_NORMAL;
      end
    end
  end

  assign pixels_o = {color[0], color[1], color[2], color[3],
                     color[4], color[5], color[6], color[7]};

endmodule

FILE: src/attribute_video_memory_pixel_unit_core.sv
// Attribute video memory pixel unit: bitmap memory, attribute plane and latch.
// Uses avmpu_pkg, avmpu_store and avmpu_pixel.
//
// Usage: a transaction is taken at a rising edge where start_i is high and
// busy_o is low. mode_i selects latch read, latch write, CPU read, CPU write
// or display fetch of one column; the other inputs carry its operands.
// Every transaction yields exactly one result: done_o is high for a single
// cycle with read_data_o and pixels_o valid, after the input, memory read and
// result registers. Fields that do not apply to the operation read as zero.
// Throughput is one transaction per clock while busy_o is low: an input
// register, the memory read register and the result register form a
// three-stage pipeline; the latch is forwarded so back-to-back CPU
// accesses see each other. After reset busy_o stays high while both memories
// are swept to zero, one address per cycle: 2**MEM_ADDR_BITS (32768 default).
// The receiver cannot stall; results must be taken when done_o is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module attribute_video_memory_pixel_unit_core #(
  parameter int unsigned MEM_ADDR_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [15:0] cpu_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [12:0] start_address_i,
  input  logic [7:0]  column_i,
  input  logic [1:0]  raster_row_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic [15:0] pixels_o
);

  // Access stage registers.
  logic                     s1_valid_q;
  logic [2:0]               s1_mode_q;
  logic [MEM_ADDR_BITS-1:0] s1_addr_q;
  logic [7:0]               s1_wdata_q;
  logic [12:0]              s1_start_q;
  logic [7:0]               s1_col_q;
  logic [1:0]               s1_row_q;

  // Result stage registers.
  logic                     s2_valid_q;
  logic [2:0]               s2_mode_q;
  logic                     s2_attr_hi_q;
  logic [7:0]               s2_wdata_q;

  logic                     out_valid_q;
  logic [7:0]               read_data_q, read_data_d;
  logic [15:0]              pixels_q, pixels_d;
  logic [7:0]               latch_q, latch_d;

  logic                     accept;
  logic                     clearing;
  logic [13:0]              disp_sum;
  logic [15:0]              disp_full;
  logic [MEM_ADDR_BITS-1:0] mem_addr;
  logic                     attr_hi;
  avmpu_pkg::mem_req_t      mem_req;
  logic [7:0]               vdata;
  logic [1:0]               adata;
  logic [15:0]              fetch_pixels;

  assign busy_o = clearing;
  assign accept = start_i & ~clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      latch_q     <= '0;
    end else begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      latch_q     <= latch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= mode_i;
      s1_addr_q  <= cpu_address_i[MEM_ADDR_BITS-1:0];
      s1_wdata_q <= write_data_i;
      s1_start_q <= start_address_i;
      s1_col_q   <= column_i;
      s1_row_q   <= raster_row_i;
    end
    s2_mode_q    <= s1_mode_q;
    s2_attr_hi_q <= attr_hi;
    s2_wdata_q   <= s1_wdata_q;
    read_data_q  <= read_data_d;
    pixels_q     <= pixels_d;
  end

  // Display address: the plane (raster row plus one) sits above bit 12 and
  // the carry of the start plus column sum is ORed into it.
  assign disp_sum  = {1'b0, s1_start_q} + {6'b0, s1_col_q};
  assign disp_full = {({1'b0, s1_row_q} + 3'd1), 13'b0} | {2'b0, disp_sum};
  assign mem_addr  = (s1_mode_q == avmpu_pkg::MODE_FETCH) ?
                     disp_full[MEM_ADDR_BITS-1:0] : s1_addr_q;
  assign attr_hi   = s1_addr_q >= avmpu_pkg::ATTR_SPLIT[MEM_ADDR_BITS-1:0];

  // Latch commits in the result stage; the access stage sees its next value.
  always_comb begin
    latch_d = latch_q;
    if (s2_valid_q) begin
      case (s2_mode_q)
        avmpu_pkg::MODE_WR_LATCH: latch_d = s2_wdata_q;
        avmpu_pkg::MODE_CPU_RD: begin
          if (s2_attr_hi_q) begin
            latch_d = {latch_q[7:2], adata};
          end
        end
        default: latch_d = latch_q;
      endcase
    end
  end

  always_comb begin
    mem_req.we         = s1_valid_q && (s1_mode_q == avmpu_pkg::MODE_CPU_WR);
    mem_req.attr_we    = mem_req.we && attr_hi &&
                         latch_d[avmpu_pkg::ATTR_BIT_LATCH_WE];
    mem_req.wdata      = s1_wdata_q;
    mem_req.attr_wdata = latch_d[1:0];
  end

  avmpu_store #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .addr_i     (mem_addr),
    .req_i      (mem_req),
    .vdata_o    (vdata),
    .adata_o    (adata),
    .clearing_o (clearing)
  );

  avmpu_pixel u_pixel (
    .data_i   (vdata),
    .attr_i   ({latch_q[7:2], adata}),
    .pixels_o (fetch_pixels)
  );

  always_comb begin
    read_data_d = '0;
    pixels_d    = '0;
    case (s2_mode_q)
      avmpu_pkg::MODE_RD_LATCH: read_data_d = latch_q;
      avmpu_pkg::MODE_CPU_RD:   read_data_d = vdata;
      avmpu_pkg::MODE_FETCH:    pixels_d    = fetch_pixels;
      default: begin
        read_data_d = '0;
        pixels_d    = '0;
      end
    endcase
  end

  assign done_o      = out_valid_q;
  assign read_data_o = read_data_q;
  assign pixels_o    = pixels_q;

  `ASSERT_AT(a_result_latency, start_i && !busy_o |-> ##3 done_o)
  `ASSERT_NEVER(a_no_work_in_clear, busy_o && (s1_valid_q || s2_valid_q))
  `ASSERT_AT(a_pixels_from_fetch, done_o && pixels_o != '0 |-> $past(s2_mode_q) == avmpu_pkg::MODE_FETCH)

endmodule
